// ----- hw/rtl/spq_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package spq_pkg;

  localparam int unsigned Depth = 16;
  localparam int unsigned SlotW = $clog2(Depth);
  localparam int unsigned CntW  = $clog2(Depth + 1);

  typedef enum logic {
    FUNC_INSERT = 1'b0,
    FUNC_REMOVE = 1'b1
  } func_e;

  typedef enum logic [1:0] {
    STATUS_DONE  = 2'd0,
    STATUS_FULL  = 2'd1,
    STATUS_EMPTY = 2'd2
  } status_e;

  typedef struct packed {
    func_e              func;
    logic signed [15:0] priority_req;
    logic        [15:0] tag;
  } req_t;

  typedef struct packed {
    status_e            status;
    logic signed [15:0] out_priority;
    logic        [15:0] out_tag;
    logic        [4:0]  occupancy;
  } rsp_t;

  typedef struct packed {
    logic signed [15:0] prio;
    logic        [15:0] tag;
  } entry_t;

  typedef struct packed {
    logic insert;
    logic remove;
  } ctrl_t;

endpackage

`default_nettype wire

// ----- hw/rtl/spq_cell.sv -----
`timescale 1ns / 1ps
`default_nettype none

module spq_cell (
  input  wire logic            clk_i,
  input  wire spq_pkg::ctrl_t  ctrl_i,
  input  wire logic            is_head_i,
  input  wire logic            occ_i,
  input  wire spq_pkg::entry_t new_i,
  input  wire spq_pkg::entry_t left_i,
  input  wire logic            left_before_i,
  input  wire spq_pkg::entry_t right_i,
  output spq_pkg::entry_t      entry_o,
  output logic                 before_o
);

  spq_pkg::entry_t entry_q, entry_d;
  logic            gt, eq;

  assign gt = $signed(entry_q.prio) > $signed(new_i.prio);
  assign eq = entry_q.prio == new_i.prio;

  // An equal head keeps first place, so the head counts ties as ahead.
  assign before_o = occ_i & (gt | (is_head_i & eq));

  always_comb begin
    entry_d = entry_q;
    if (ctrl_i.insert) begin
      if (!before_o) begin
        entry_d = left_before_i ? new_i : left_i;
      end
    end else if (ctrl_i.remove) begin
      entry_d = right_i;
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

  assign entry_o = entry_q;

endmodule

`default_nettype wire

// ----- hw/rtl/sorted_priority_queue.sv -----
// Sorted priority queue of (priority, tag) entries, highest priority first.
//
// Commands: raise start with req_i for one cycle; a beat is taken at a rising
// edge where start is high and busy is low. busy stays low, so one command
// can be taken in every cycle. func selects insert or remove-head.
//
// Results: exactly one result per command, shown on rsp_o with valid_o high
// for one cycle, the cycle right after the command edge.
// The receiver cannot stall; each result must be taken when shown.
//
// Storage is a row of cells, one per slot. On insert every cell compares its
// priority with the new one in the same cycle; cells behind the insert point
// take their left neighbor and the slot itself takes the new entry. On remove
// every cell but the tail takes its right neighbor. Ties go ahead of equal
// entries, but an equal head stays in front and the new entry lands behind it.
//
// Reset clears the fill count and the result strobe; slot contents are
// meaningless until written and are never shown before then.
`timescale 1ns / 1ps
`default_nettype none

module sorted_priority_queue (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           start,
  output logic                busy,
  input  wire spq_pkg::req_t  req_i,
  output logic                valid_o,
  output spq_pkg::rsp_t       rsp_o
);

  localparam int unsigned Depth = spq_pkg::Depth;
  localparam int unsigned CntW  = spq_pkg::CntW;

  logic                       accept;
  logic                       full, empty;
  logic                       ins_ok, rem_ok;
  spq_pkg::ctrl_t             ctrl;
  spq_pkg::entry_t            new_entry;
  spq_pkg::entry_t            entry   [Depth];
  logic [Depth-1:0]           ahead;
  logic [Depth-1:0]           occ;
  logic [CntW-1:0]            count_q, count_d;
  logic                       valid_q;
  spq_pkg::rsp_t              rsp_q, rsp_d;

  assign busy   = 1'b0;
  assign accept = start & ~busy;
  assign full   = count_q == CntW'(Depth);
  assign empty  = count_q == '0;
  assign ins_ok = accept & (req_i.func == spq_pkg::FUNC_INSERT) & ~full;
  assign rem_ok = accept & (req_i.func == spq_pkg::FUNC_REMOVE) & ~empty;

  assign ctrl.insert    = ins_ok;
  assign ctrl.remove    = rem_ok;
  assign new_entry.prio = req_i.priority_req;
  assign new_entry.tag  = req_i.tag;

  for (genvar i = 0; i < Depth; i++) begin : g_cell
    assign occ[i] = CntW'(i) < count_q;

    if (i == 0) begin : g_head
      spq_cell u_cell (
        .clk_i         (clk_i),
        .ctrl_i        (ctrl),
        .is_head_i     (1'b1),
        .occ_i         (occ[i]),
        .new_i         (new_entry),
        .left_i        (new_entry),
        .left_before_i (1'b1),
        .right_i       (entry[i+1]),
        .entry_o       (entry[i]),
        .before_o      (ahead[i])
      );
    end else if (i == Depth - 1) begin : g_tail
      spq_cell u_cell (
        .clk_i         (clk_i),
        .ctrl_i        (ctrl),
        .is_head_i     (1'b0),
        .occ_i         (occ[i]),
        .new_i         (new_entry),
        .left_i        (entry[i-1]),
        .left_before_i (ahead[i-1]),
        .right_i       (entry[i]),
        .entry_o       (entry[i]),
        .before_o      (ahead[i])
      );
    end else begin : g_mid
      spq_cell u_cell (
        .clk_i         (clk_i),
        .ctrl_i        (ctrl),
        .is_head_i     (1'b0),
        .occ_i         (occ[i]),
        .new_i         (new_entry),
        .left_i        (entry[i-1]),
        .left_before_i (ahead[i-1]),
        .right_i       (entry[i+1]),
        .entry_o       (entry[i]),
        .before_o      (ahead[i])
      );
    end
  end

  always_comb begin
    count_d = count_q;
    if (ins_ok) begin
      count_d = count_q + CntW'(1);
    end else if (rem_ok) begin
      count_d = count_q - CntW'(1);
    end
  end

  always_comb begin
    rsp_d.status       = spq_pkg::STATUS_DONE;
    rsp_d.out_priority = '0;
    rsp_d.out_tag      = '0;
    rsp_d.occupancy    = 5'(count_d);
    if (req_i.func == spq_pkg::FUNC_INSERT) begin
      if (full) begin
        rsp_d.status = spq_pkg::STATUS_FULL;
      end
    end else if (empty) begin
      rsp_d.status = spq_pkg::STATUS_EMPTY;
    end else begin
      rsp_d.out_priority = entry[0].prio;
      rsp_d.out_tag      = entry[0].tag;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      valid_q <= 1'b0;
    end else begin
      count_q <= count_d;
      valid_q <= accept;
    end
  end

  // Hold the last result payload; only the strobe marks a new beat.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      rsp_q <= rsp_d;
    end
  end

  assign valid_o = valid_q;
  assign rsp_o   = rsp_q;

endmodule

`default_nettype wire

// ----- hw/rtl/spq_chk.sv -----
`timescale 1ns / 1ps
`default_nettype none

module spq_chk (
  input wire logic          clk_i,
  input wire logic          rst_ni,
  input wire logic          start,
  input wire logic          busy,
  input wire logic          valid_o,
  input wire spq_pkg::rsp_t rsp_o
);

  // Every command beat yields a result in the next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> valid_o)
    else $error("spq: command beat without result");

  // No result without a command beat before it.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> $past(start && !busy))
    else $error("spq: result without command");

  // Refused or empty results carry no entry.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && rsp_o.status != spq_pkg::STATUS_DONE) |->
      (rsp_o.out_priority == '0 && rsp_o.out_tag == '0))
    else $error("spq: payload on failed command");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && rsp_o.status == spq_pkg::STATUS_FULL) |->
      (rsp_o.occupancy == 5'(spq_pkg::Depth)))
    else $error("spq: full status with room left");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && rsp_o.status == spq_pkg::STATUS_EMPTY) |->
      (rsp_o.occupancy == '0))
    else $error("spq: empty status with entries held");

endmodule

bind sorted_priority_queue spq_chk u_spq_chk (
  .clk_i   (clk_i),
  .rst_ni  (rst_ni),
  .start   (start),
  .busy    (busy),
  .valid_o (valid_o),
  .rsp_o   (rsp_o)
);

`default_nettype wire
